FILE: design/pfr_pkg.sv
// ----------------------------------------------------------------------------
// pfr_pkg
// Types, codes and the frame class lookup of the panel frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package pfr_pkg;

  localparam logic [1:0] PH_LEN  = 2'd0;
  localparam logic [1:0] PH_CMD  = 2'd1;
  localparam logic [1:0] PH_SUB  = 2'd2;
  localparam logic [1:0] PH_DATA = 2'd3;

  localparam logic [7:0] CMD_INIT    = 8'h00;
  localparam logic [7:0] CMD_ACK     = 8'h40;
  localparam logic [7:0] CMD_PANEL_A = 8'h80;
  localparam logic [7:0] CMD_PANEL_B = 8'h81;
  localparam logic [7:0] CMD_IGNORE  = 8'hFF;

  localparam logic [7:0] SUB_RESET     = 8'h01;
  localparam logic [7:0] SUB_SERIAL    = 8'h02;
  localparam logic [7:0] SUB_TEXT      = 8'h03;
  localparam logic [7:0] SUB_HEARTBEAT = 8'h10;

  localparam logic [7:0] LEN_MIN = 8'd2;

  localparam logic [3:0] CLS_INIT      = 4'd0;
  localparam logic [3:0] CLS_ACK       = 4'd1;
  localparam logic [3:0] CLS_RESET     = 4'd2;
  localparam logic [3:0] CLS_SERIAL    = 4'd3;
  localparam logic [3:0] CLS_TEXT      = 4'd4;
  localparam logic [3:0] CLS_HEARTBEAT = 4'd5;
  localparam logic [3:0] CLS_BAD_SUB   = 4'd6;
  localparam logic [3:0] CLS_IGNORED   = 4'd7;
  localparam logic [3:0] CLS_UNKNOWN   = 4'd8;

  typedef struct packed {
    logic [1:0] phase;
    logic [7:0] remaining;
    logic [7:0] length_seen;
    logic [7:0] command;
    logic [7:0] subcommand;
    logic [7:0] data_seen;
  } pfr_state_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       frame_done;
    logic       ack_request;
    logic       ack_seen;
    logic [3:0] frame_class;
    logic [7:0] frame_command;
    logic [7:0] frame_subcommand;
    logic [7:0] data_count;
    logic [7:0] frame_length;
  } pfr_result_t;

  function automatic logic [3:0] pfr_classify(input logic [7:0] cmd, input logic [7:0] sub);
    logic [3:0] cls;
    priority if (cmd == CMD_INIT) begin
      cls = CLS_INIT;
    end else if (cmd == CMD_ACK) begin
      cls = CLS_ACK;
    end else if (cmd == CMD_PANEL_A || cmd == CMD_PANEL_B) begin
      priority if (sub == SUB_RESET) begin
        cls = CLS_RESET;
      end else if (sub == SUB_SERIAL) begin
        cls = CLS_SERIAL;
      end else if (sub == SUB_TEXT) begin
        cls = CLS_TEXT;
      end else if (sub == SUB_HEARTBEAT) begin
        cls = CLS_HEARTBEAT;
      end else begin
        cls = CLS_BAD_SUB;
      end
    end else if (cmd == CMD_IGNORE) begin
      cls = CLS_IGNORED;
    end else begin
      cls = CLS_UNKNOWN;
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

FILE: design/panel_frame_receiver.sv
// ----------------------------------------------------------------------------
// panel_frame_receiver
// Parses a serial byte stream into panel frames and reports each byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries one received byte (in_rx_byte)
//   per transfer. Every input transfer yields exactly one result transfer on
//   out_valid/out_stall: data bytes with their index, and at frame end the
//   acknowledge request, ACK-seen flag, class, command, data count and length.
//   The result is registered: the result register holds the result from the
//   clock after the input transfer. Throughput is one byte per cycle while no
//   result waits under out_stall; the parser step between the frame state and
//   the result register is combinational.
//   While a result waits under out_stall, in_stall is raised and the frame
//   state and result hold; a byte is taken in the same cycle the waiting
//   result is taken.
//   Reset (rst_n low, synchronous) empties the result register and returns
//   the parser to expecting a length byte with all counters cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module panel_frame_receiver (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_payload_valid,
  output logic [7:0]      out_payload_byte,
  output logic [7:0]      out_payload_index,
  output logic            out_frame_done,
  output logic            out_ack_request,
  output logic            out_ack_seen,
  output logic [3:0]      out_frame_class,
  output logic [7:0]      out_frame_command,
  output logic [7:0]      out_frame_subcommand,
  output logic [7:0]      out_data_count,
  output logic [7:0]      out_frame_length
);
  import pfr_pkg::*;

  pfr_state_t  st_r;
  pfr_state_t  st_nxt;
  pfr_result_t res_r;
  pfr_result_t res_nxt;
  logic        out_valid_r;
  logic        in_take;

  assign in_stall = out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  pfr_parse u_parse (
    .rx_byte (in_rx_byte),
    .st      (st_r),
    .st_nxt  (st_nxt),
    .res     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        st_r <= st_nxt;
      end
      if (in_take) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_payload_valid    = res_r.payload_valid;
  assign out_payload_byte     = res_r.payload_byte;
  assign out_payload_index    = res_r.payload_index;
  assign out_frame_done       = res_r.frame_done;
  assign out_ack_request      = res_r.ack_request;
  assign out_ack_seen         = res_r.ack_seen;
  assign out_frame_class      = res_r.frame_class;
  assign out_frame_command    = res_r.frame_command;
  assign out_frame_subcommand = res_r.frame_subcommand;
  assign out_data_count       = res_r.data_count;
  assign out_frame_length     = res_r.frame_length;

endmodule

`default_nettype wire

FILE: design/pfr_parse.sv
// ----------------------------------------------------------------------------
// pfr_parse
// One parser step: next frame state and the result for one received byte.
// ----------------------------------------------------------------------------
`default_nettype none

module pfr_parse (
  input  wire logic [7:0]          rx_byte,
  input  wire pfr_pkg::pfr_state_t st,
  output pfr_pkg::pfr_state_t      st_nxt,
  output pfr_pkg::pfr_result_t     res
);
  import pfr_pkg::*;

  pfr_state_t  s;
  pfr_result_t r;

  always_comb begin
    s = st;
    r = '0;
    unique case (st.phase)
      PH_LEN: begin
        s.remaining   = rx_byte;
        s.length_seen = rx_byte;
        s.phase       = PH_CMD;
      end
      PH_CMD: begin
        s.command   = rx_byte;
        s.phase     = (rx_byte == CMD_PANEL_A || rx_byte == CMD_PANEL_B) ? PH_SUB : PH_DATA;
        s.remaining = st.remaining - 8'd1;
      end
      PH_SUB: begin
        s.subcommand = rx_byte;
        s.phase      = PH_DATA;
        s.remaining  = st.remaining - 8'd1;
      end
      PH_DATA: begin
        r.payload_valid = 1'b1;
        r.payload_byte  = rx_byte;
        r.payload_index = st.data_seen;
        s.data_seen     = st.data_seen + 8'd1;
        s.remaining     = st.remaining - 8'd1;
      end
    endcase

    if (s.remaining < LEN_MIN) begin
      r.frame_done    = 1'b1;
      r.ack_request   = (s.command != CMD_ACK);
      r.ack_seen      = (s.command == CMD_ACK);
      r.frame_class   = pfr_classify(s.command, s.subcommand);
      r.frame_command = s.command;
      r.data_count    = s.data_seen;
      r.frame_length  = s.length_seen;
      s.phase         = PH_LEN;
      s.data_seen     = 8'd0;
      s.command       = CMD_INIT;
    end
    r.frame_subcommand = s.subcommand;

    st_nxt = s;
    res    = r;
  end

endmodule

`default_nettype wire

FILE: design/pfr_checker.sv
// ----------------------------------------------------------------------------
// pfr_checker
// Port-level checks of the panel frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pfr_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [7:0] in_rx_byte,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_payload_valid,
  input wire logic [7:0] out_payload_byte,
  input wire logic [7:0] out_payload_index,
  input wire logic       out_frame_done,
  input wire logic       out_ack_request,
  input wire logic       out_ack_seen,
  input wire logic [3:0] out_frame_class,
  input wire logic [7:0] out_data_count,
  input wire logic [7:0] out_frame_length
);
  import pfr_pkg::*;

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload_byte)
      && $stable(out_frame_done) && $stable(out_frame_class))
    else $error("stalled result changed");

  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_done |-> !out_ack_request && !out_ack_seen
      && out_frame_class == CLS_INIT && out_data_count == 8'd0
      && out_frame_length == 8'd0)
    else $error("frame fields set without frame end");

  a_ack_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_ack_request != out_ack_seen)
    else $error("ack request and ack seen not exclusive");

  a_data_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid && (out_payload_valid
      ? out_payload_byte == $past(in_rx_byte) : out_payload_index == 8'd0))
    else $error("result does not match transferred byte");

endmodule

bind panel_frame_receiver pfr_checker u_pfr_checker (.*);

`default_nettype wire
